FILE: src/dsig_pkg.sv
// dsig_pkg: shared types, microcode encoding and program for the sigma_x block
// used by dsig_seq, dsig_mul and divisor_sigma_from_factors
package dsig_pkg;

	localparam int WIDTH_DEF = 64;
	localparam int PC_W      = 4;

	typedef logic [PC_W-1:0] pc_t;

	// multiplier operand pair and destination of its result
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_ACC_BASE,
		MUL_BASE_BASE,
		MUL_SUM_Q,
		MUL_PROD_SUM
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_LOAD,
		ACT_SHIFT_PW,
		ACT_HORNER_INIT,
		ACT_HORNER_STEP,
		ACT_EMIT
	} act_t;

	typedef enum logic [2:0] {
		J_NONE,
		J_ALWAYS,
		J_PW_ZERO,
		J_PW_EVEN,
		J_CNT_ZERO
	} cond_t;

	typedef struct packed {
		mul_sel_t mul;
		act_t     act;
		cond_t    cond;
		pc_t      target;
	} ctrl_t;

	typedef struct packed {
		ctrl_t ctrl;
		logic  go;
		logic  mul_start;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic out_free;
		logic mul_done;
		logic pw_zero;
		logic pw_even;
		logic cnt_zero;
	} flags_t;

	// program addresses
	localparam pc_t PC_LOAD     = 4'd0;
	localparam pc_t PC_POW_TEST = 4'd1;
	localparam pc_t PC_POW_BIT  = 4'd2;
	localparam pc_t PC_POW_MUL  = 4'd3;
	localparam pc_t PC_POW_SQR  = 4'd4;
	localparam pc_t PC_H_INIT   = 4'd5;
	localparam pc_t PC_H_TEST   = 4'd6;
	localparam pc_t PC_H_STEP   = 4'd7;
	localparam pc_t PC_PROD     = 4'd8;
	localparam pc_t PC_EMIT     = 4'd9;

	function automatic ctrl_t ucode(input pc_t pc);
		ctrl_t w;
		w = '{mul: MUL_NONE, act: ACT_NONE, cond: J_ALWAYS, target: PC_LOAD};
		case (pc)
			PC_LOAD:     w = '{MUL_NONE,      ACT_LOAD,        J_NONE,     PC_LOAD};
			PC_POW_TEST: w = '{MUL_NONE,      ACT_NONE,        J_PW_ZERO,  PC_H_INIT};
			PC_POW_BIT:  w = '{MUL_NONE,      ACT_NONE,        J_PW_EVEN,  PC_POW_SQR};
			PC_POW_MUL:  w = '{MUL_ACC_BASE,  ACT_NONE,        J_NONE,     PC_LOAD};
			PC_POW_SQR:  w = '{MUL_BASE_BASE, ACT_SHIFT_PW,    J_ALWAYS,   PC_POW_TEST};
			PC_H_INIT:   w = '{MUL_NONE,      ACT_HORNER_INIT, J_NONE,     PC_LOAD};
			PC_H_TEST:   w = '{MUL_NONE,      ACT_NONE,        J_CNT_ZERO, PC_PROD};
			PC_H_STEP:   w = '{MUL_SUM_Q,     ACT_HORNER_STEP, J_ALWAYS,   PC_H_TEST};
			PC_PROD:     w = '{MUL_PROD_SUM,  ACT_NONE,        J_NONE,     PC_LOAD};
			PC_EMIT:     w = '{MUL_NONE,      ACT_EMIT,        J_ALWAYS,   PC_LOAD};
			default:     w = '{MUL_NONE,      ACT_NONE,        J_ALWAYS,   PC_LOAD};
		endcase
		return w;
	endfunction

endpackage

FILE: src/dsig_mul.sv
// dsig_mul: WIDTH x WIDTH multiplier, low WIDTH bits, from three half-width
// partial products on one shared multiplier; default width from dsig_pkg
module dsig_mul #(
	parameter int WIDTH = dsig_pkg::WIDTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] a,
	input  logic [WIDTH-1:0] b,
	output logic             busy,
	output logic             done,
	output logic [WIDTH-1:0] result
);

	localparam int H = (WIDTH + 1) / 2;

	localparam logic [1:0] PH_LL  = 2'd0;
	localparam logic [1:0] PH_LH  = 2'd1;
	localparam logic [1:0] PH_HL  = 2'd2;
	localparam logic [1:0] PH_END = 2'd3;

	logic             busy_q;
	logic [1:0]       ph_q;
	logic [1:0]       ph;
	logic [H-1:0]     a_lo, a_hi, b_lo, b_hi;
	logic [H-1:0]     op_a, op_b;
	logic [2*H-1:0]   prod_q;
	logic [WIDTH-1:0] acc_q;
	logic [WIDTH-1:0] prod_sh;

	assign a_lo = a[H-1:0];
	assign b_lo = b[H-1:0];
	assign a_hi = H'(a[WIDTH-1:H]);
	assign b_hi = H'(b[WIDTH-1:H]);

	assign ph = busy_q ? ph_q : PH_LL;

	always_comb begin
		case (ph)
			PH_LL: begin
				op_a = a_lo;
				op_b = b_lo;
			end
			PH_LH: begin
				op_a = a_lo;
				op_b = b_hi;
			end
			PH_HL: begin
				op_a = a_hi;
				op_b = b_lo;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// cross terms only matter above the low half
	assign prod_sh = WIDTH'(prod_q) << H;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= PH_LL;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				ph_q   <= PH_LH;
			end
		end else if (ph_q == PH_END) begin
			busy_q <= 1'b0;
		end else begin
			ph_q <= 2'(ph_q + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
		if (busy_q && ph_q == PH_LH)
			acc_q <= WIDTH'(prod_q);
		else if (busy_q && ph_q == PH_HL)
			acc_q <= acc_q + prod_sh;
	end

	assign busy   = busy_q;
	assign done   = busy_q && (ph_q == PH_END);
	assign result = acc_q + prod_sh;

endmodule

FILE: src/dsig_seq.sv
// dsig_seq: step counter, microcode table lookup and branch logic
// depends on dsig_pkg for the control word and program
module dsig_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  dsig_pkg::flags_t flags,
	input  logic            mul_busy,
	output dsig_pkg::cmd_t  cmd
);

	dsig_pkg::pc_t   pc_q;
	dsig_pkg::pc_t   pc_next;
	dsig_pkg::ctrl_t w;
	logic            ready;
	logic            take;

	assign w = dsig_pkg::ucode(pc_q);

	// a step finishes once its multiply and its handshake are done
	always_comb begin
		ready = 1'b1;
		if (w.mul != dsig_pkg::MUL_NONE && !flags.mul_done)
			ready = 1'b0;
		if (w.act == dsig_pkg::ACT_LOAD && !flags.in_valid)
			ready = 1'b0;
		if (w.act == dsig_pkg::ACT_EMIT && !flags.out_free)
			ready = 1'b0;
	end

	always_comb begin
		case (w.cond)
			dsig_pkg::J_NONE:     take = 1'b0;
			dsig_pkg::J_ALWAYS:   take = 1'b1;
			dsig_pkg::J_PW_ZERO:  take = flags.pw_zero;
			dsig_pkg::J_PW_EVEN:  take = flags.pw_even;
			dsig_pkg::J_CNT_ZERO: take = flags.cnt_zero;
			default:              take = 1'b0;
		endcase
	end

	always_comb begin
		pc_next = pc_q;
		if (ready)
			pc_next = take ? w.target : dsig_pkg::pc_t'(pc_q + 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pc_q <= dsig_pkg::PC_LOAD;
		else
			pc_q <= pc_next;
	end

	assign cmd.ctrl      = w;
	assign cmd.go        = ready;
	assign cmd.mul_start = (w.mul != dsig_pkg::MUL_NONE) && !mul_busy;

endmodule

FILE: src/divisor_sigma_from_factors.sv
// Computes sigma_x(n) from a stream of prime powers (prime, exponent, last_factor), one result
// item per input item carrying the running product modulo 2^WIDTH; the product returns to 1
// after an item marked last. One item at a time is worked by a microcoded sequencer driving a
// single multiplier built from three half-width partial products. An item is emitted only
// once the output register is free, so out_stall can hold it back. power_x is written
// through the cfg channel, which is always ready, and must only change while the block is idle.
module divisor_sigma_from_factors #(
	parameter int WIDTH = dsig_pkg::WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  power_x,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] prime,
	input  logic [5:0]  exponent,
	input  logic        last_factor,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] product_value,
	output logic        is_final
);

	localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

	logic [7:0]       power_x_q;
	logic [WIDTH-1:0] base_q, acc_q, sum_q, prod_q;
	logic [7:0]       pw_q;
	logic [5:0]       cnt_q;
	logic             last_q;
	logic             out_valid_q;
	logic [WIDTH-1:0] out_value_q;
	logic             out_final_q;

	logic [WIDTH-1:0] mul_a, mul_b, mul_result;
	logic             mul_busy, mul_done;
	dsig_pkg::flags_t flags;
	dsig_pkg::cmd_t   cmd;
	logic             out_free;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			power_x_q <= '0;
		else if (cfg_valid)
			power_x_q <= power_x;
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (cmd.ctrl.act != dsig_pkg::ACT_LOAD);

	assign flags.in_valid = in_valid;
	assign flags.out_free = out_free;
	assign flags.mul_done = mul_done;
	assign flags.pw_zero  = (pw_q == '0);
	assign flags.pw_even  = !pw_q[0];
	assign flags.cnt_zero = (cnt_q == '0);

	dsig_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.flags    (flags),
		.mul_busy (mul_busy),
		.cmd      (cmd)
	);

	// acc holds p^x once the power loop ends and serves as q in the horner steps
	always_comb begin
		case (cmd.ctrl.mul)
			dsig_pkg::MUL_ACC_BASE: begin
				mul_a = acc_q;
				mul_b = base_q;
			end
			dsig_pkg::MUL_BASE_BASE: begin
				mul_a = base_q;
				mul_b = base_q;
			end
			dsig_pkg::MUL_SUM_Q: begin
				mul_a = sum_q;
				mul_b = acc_q;
			end
			dsig_pkg::MUL_PROD_SUM: begin
				mul_a = prod_q;
				mul_b = sum_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	dsig_mul #(
		.WIDTH (WIDTH)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.result (mul_result)
	);

	// working registers
	always_ff @(posedge clk) begin
		if (cmd.go) begin
			case (cmd.ctrl.act)
				dsig_pkg::ACT_LOAD: begin
					base_q <= prime[WIDTH-1:0];
					pw_q   <= power_x_q;
					acc_q  <= ONE;
					cnt_q  <= exponent;
					last_q <= last_factor;
				end
				dsig_pkg::ACT_SHIFT_PW:    pw_q  <= pw_q >> 1;
				dsig_pkg::ACT_HORNER_INIT: sum_q <= ONE;
				dsig_pkg::ACT_HORNER_STEP: cnt_q <= 6'(cnt_q - 6'd1);
				default: ;
			endcase
			case (cmd.ctrl.mul)
				dsig_pkg::MUL_ACC_BASE:  acc_q  <= mul_result;
				dsig_pkg::MUL_BASE_BASE: base_q <= mul_result;
				dsig_pkg::MUL_SUM_Q:     sum_q  <= mul_result + ONE;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_q <= ONE;
		end else if (cmd.go) begin
			if (cmd.ctrl.mul == dsig_pkg::MUL_PROD_SUM)
				prod_q <= mul_result;
			else if (cmd.ctrl.act == dsig_pkg::ACT_EMIT && last_q)
				prod_q <= ONE;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.go && cmd.ctrl.act == dsig_pkg::ACT_EMIT)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.go && cmd.ctrl.act == dsig_pkg::ACT_EMIT) begin
			out_value_q <= prod_q;
			out_final_q <= last_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign product_value = 64'(out_value_q);
	assign is_final      = out_final_q;

	// an accepted item keeps the input closed while it is worked
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after item accepted");

	a_prod_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.go && cmd.ctrl.act == dsig_pkg::ACT_EMIT && last_q) |=> (prod_q == ONE))
		else $error("running product not restarted after final item");

	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (cmd.ctrl.mul != dsig_pkg::MUL_NONE))
		else $error("multiply finished outside a multiply step");

endmodule
